@@ sv/dsac_pkg.sv @@
// Package for the dual serial ADC capture block: constants, codes and payload types.
package dsac_pkg;

    localparam int SAMPLE_BITS     = 14;
    localparam int TICK_COUNT_BITS = 24;
    localparam int BIT_IDX_W       = $clog2(SAMPLE_BITS);

    localparam int GAIN_W     = 18;
    localparam int GAIN_FRAC  = 16;
    localparam int TICKS_W    = 24;
    localparam int SCALED_W   = 15;
    localparam int TIMEOUTS_W = 8;
    localparam int CMP_W      = 32;
    localparam int PROD_W     = SAMPLE_BITS + GAIN_W;
    localparam int SHIFTED_W  = PROD_W - GAIN_FRAC;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET     = GAIN_W'(79574);
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET  = TICKS_W'(1000);
    localparam logic [TICKS_W-1:0] INTERVAL_RESET = TICKS_W'(1000000);

    localparam logic [SCALED_W-1:0]   SCALED_MAX   = '1;
    localparam logic [TIMEOUTS_W-1:0] TIMEOUTS_MAX = '1;
    localparam logic [BIT_IDX_W-1:0]  BIT_IDX_TOP  = BIT_IDX_W'(SAMPLE_BITS - 1);

    typedef enum logic [2:0] {
        PH_START,
        PH_WAIT,
        PH_MSB,
        PH_LOW,
        PH_HIGH,
        PH_IDLE
    } phase_t;

    typedef struct packed {
        logic busy_level;
        logic data_a_bit;
        logic data_b_bit;
    } in_item_t;

    typedef struct packed {
        logic                   start_n;
        logic                   serial_clock;
        logic                   select_n;
        logic                   sample_valid;
        logic                   timed_out;
        logic [SAMPLE_BITS-1:0] raw_a;
        logic [SAMPLE_BITS-1:0] raw_b;
        logic [SCALED_W-1:0]    scaled_magnitude;
        logic                   negative;
        logic [TIMEOUTS_W-1:0]  timeout_count;
    } out_item_t;

endpackage

@@ sv/dual_serial_adc_capture.sv @@
// Dual serial ADC capture sequencer: one pin tick in, one pin-drive/result item out.
//
//  channel  direction  handshake                payload
//  in       input      in_valid / in_ready      in_data   (in_item_t, one pin tick)
//  out      output     out_valid / out_ready    out_data  (out_item_t, pin drives + held sample)
//  cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data (register write)
//
// One tick per cycle unless the output stalls; an accepted tick's result shows in the next cycle.
// The tick's whole update (shift, sign/magnitude, 14x18 gain multiply) is combinational.
// in_ready drops only while a result waits in the output register and out_ready is low.
// cfg_ready is always high. Reset is asynchronous, active low; all state but the output
// data register goes to its start-pulse defaults and no clearing pass is needed.
module dual_serial_adc_capture
    import dsac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [GAIN_W-1:0]  gain_reg;
    logic [TICKS_W-1:0] timeout_reg;
    logic [TICKS_W-1:0] interval_reg;

    phase_t                     phase_reg, phase_next;
    logic [TICK_COUNT_BITS-1:0] tick_reg, tick_next, tick_inc;
    logic [BIT_IDX_W-1:0]       bit_idx_reg, bit_idx_next;
    logic [SAMPLE_BITS-1:0]     shift_a_reg, shift_a_next;
    logic [SAMPLE_BITS-1:0]     shift_b_reg, shift_b_next;
    logic                       busy_prev_reg;
    logic [TIMEOUTS_W-1:0]      timeouts_reg, timeouts_next;
    logic [SAMPLE_BITS-1:0]     raw_a_reg, raw_a_next;
    logic [SAMPLE_BITS-1:0]     raw_b_reg, raw_b_next;
    logic [SCALED_W-1:0]        scaled_reg, scaled_next;
    logic                       neg_reg, neg_next;

    out_item_t out_reg, out_next;
    logic      out_valid_reg;

    logic                   accept;
    logic                   busy_fell;
    logic                   wait_expired;
    logic                   interval_done;
    logic [SAMPLE_BITS-1:0] mag;
    logic [PROD_W-1:0]      prod;
    logic [SHIFTED_W-1:0]   prod_shifted;
    logic                   start_n, sclk, sel_n, smp_valid, tout;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // saturating tick counter increment
    assign tick_inc      = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
    assign busy_fell     = busy_prev_reg && !in_data.busy_level;
    assign wait_expired  = CMP_W'(tick_inc) >= CMP_W'(timeout_reg);
    assign interval_done = CMP_W'(tick_reg) >= CMP_W'(interval_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_START: phase_next = PH_WAIT;
            PH_WAIT:
            begin
                if (busy_fell)
                    phase_next = PH_MSB;
                else if (wait_expired)
                    phase_next = PH_START;
            end
            PH_MSB:   phase_next = PH_LOW;
            PH_LOW:   phase_next = (bit_idx_reg == '0) ? PH_IDLE : PH_HIGH;
            PH_HIGH:  phase_next = PH_LOW;
            PH_IDLE:  phase_next = interval_done ? PH_START : PH_IDLE;
            default:  phase_next = PH_START;
        endcase
    end

    // datapath and pin drives
    always_comb
    begin
        tick_next     = tick_reg;
        bit_idx_next  = bit_idx_reg;
        shift_a_next  = shift_a_reg;
        shift_b_next  = shift_b_reg;
        timeouts_next = timeouts_reg;
        start_n       = 1'b1;
        sclk          = 1'b1;
        sel_n         = 1'b1;
        smp_valid     = 1'b0;
        tout          = 1'b0;
        case (phase_reg)
            PH_START:
            begin
                start_n   = 1'b0;
                tick_next = '0;
            end
            PH_WAIT:
            begin
                if (busy_fell)
                begin
                    sel_n        = 1'b0;
                    bit_idx_next = BIT_IDX_TOP;
                    shift_a_next = '0;
                    shift_b_next = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (wait_expired)
                    begin
                        tout = 1'b1;
                        if (timeouts_reg != TIMEOUTS_MAX)
                            timeouts_next = timeouts_reg + 1'b1;
                    end
                end
            end
            PH_MSB:
            begin
                sel_n        = 1'b0;
                sclk         = 1'b0;
                shift_a_next = shift_a_reg | (SAMPLE_BITS'(in_data.data_a_bit) << bit_idx_reg);
                shift_b_next = shift_b_reg | (SAMPLE_BITS'(in_data.data_b_bit) << bit_idx_reg);
                if (bit_idx_reg != '0)
                    bit_idx_next = bit_idx_reg - 1'b1;
            end
            PH_LOW:
            begin
                shift_a_next = shift_a_reg | (SAMPLE_BITS'(in_data.data_a_bit) << bit_idx_reg);
                shift_b_next = shift_b_reg | (SAMPLE_BITS'(in_data.data_b_bit) << bit_idx_reg);
                if (bit_idx_reg == '0)
                begin
                    smp_valid     = 1'b1;
                    timeouts_next = '0;
                    tick_next     = '0;
                end
                else
                begin
                    sel_n        = 1'b0;
                    bit_idx_next = bit_idx_reg - 1'b1;
                end
            end
            PH_HIGH:
            begin
                sel_n = 1'b0;
                sclk  = 1'b0;
            end
            PH_IDLE:
            begin
                if (!interval_done)
                    tick_next = tick_inc;
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    // channel A sign/magnitude and gain; true negation of the code
    assign mag          = shift_a_next[SAMPLE_BITS-1] ? (~shift_a_next + 1'b1) : shift_a_next;
    assign prod         = PROD_W'(mag) * PROD_W'(gain_reg);
    assign prod_shifted = prod[PROD_W-1:GAIN_FRAC];

    always_comb
    begin
        raw_a_next  = raw_a_reg;
        raw_b_next  = raw_b_reg;
        scaled_next = scaled_reg;
        neg_next    = neg_reg;
        if (smp_valid)
        begin
            raw_a_next  = shift_a_next;
            raw_b_next  = shift_b_next;
            neg_next    = shift_a_next[SAMPLE_BITS-1];
            scaled_next = (prod_shifted > SHIFTED_W'(SCALED_MAX)) ? SCALED_MAX
                                                                   : prod_shifted[SCALED_W-1:0];
        end
    end

    always_comb
    begin
        out_next.start_n          = start_n;
        out_next.serial_clock     = sclk;
        out_next.select_n         = sel_n;
        out_next.sample_valid     = smp_valid;
        out_next.timed_out        = tout;
        out_next.raw_a            = raw_a_next;
        out_next.raw_b            = raw_b_next;
        out_next.scaled_magnitude = scaled_next;
        out_next.negative         = neg_next;
        out_next.timeout_count    = timeouts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[TICKS_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data[TICKS_W-1:0];
                default:      gain_reg     <= gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            tick_reg      <= '0;
            bit_idx_reg   <= BIT_IDX_TOP;
            shift_a_reg   <= '0;
            shift_b_reg   <= '0;
            busy_prev_reg <= 1'b1;
            timeouts_reg  <= '0;
            raw_a_reg     <= '0;
            raw_b_reg     <= '0;
            scaled_reg    <= '0;
            neg_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_idx_reg   <= bit_idx_next;
            shift_a_reg   <= shift_a_next;
            shift_b_reg   <= shift_b_next;
            busy_prev_reg <= in_data.busy_level;
            timeouts_reg  <= timeouts_next;
            raw_a_reg     <= raw_a_next;
            raw_b_reg     <= raw_b_next;
            scaled_reg    <= scaled_next;
            neg_reg       <= neg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_START) |=> phase_reg == PH_WAIT)
        else $error("start tick not followed by wait phase");

    a_bit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_idx_reg <= BIT_IDX_TOP)
        else $error("bit index out of range");

    a_sample_clears_timeouts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.sample_valid) |-> (out_data.timeout_count == '0
            && !out_data.timed_out && out_data.select_n))
        else $error("sample result with timeout or select inconsistency");

    a_start_pulse_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.start_n) |-> (out_data.select_n && out_data.serial_clock))
        else $error("start pulse overlaps readout");
`endif

endmodule

@@ sim/dual_serial_adc_capture_tb.sv @@
// Testbench for the dual serial ADC capture sequencer: pin-tick predictor and scoreboard.
module dual_serial_adc_capture_tb;
    import dsac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam out_item_t NO_CHECK = '0;
    localparam out_item_t START_PULSE = '{start_n: 1'b0, serial_clock: 1'b1,
                                          select_n: 1'b1, default: '0};
    localparam out_item_t BUSY_EDGE = '{start_n: 1'b1, serial_clock: 1'b1,
                                        select_n: 1'b0, default: '0};
    // most negative A, most positive B, reset gain: 8192 * 79574 >> 16
    localparam out_item_t FULL_SCALE = '{start_n: 1'b1, serial_clock: 1'b1, select_n: 1'b1,
                                         sample_valid: 1'b1, timed_out: 1'b0,
                                         raw_a: 14'h2000, raw_b: 14'h1FFF,
                                         scaled_magnitude: 15'd9946, negative: 1'b1,
                                         timeout_count: 8'd0};

    localparam logic [SAMPLE_BITS-1:0] CORNER_CODES [4] = '{14'h0000, 14'h1FFF,
                                                            14'h2000, 14'h3FFF};

    typedef struct packed {
        in_item_t  pins;
        logic      typed;
        out_item_t want;
    } pin_row_t;

    // pins are {busy, a, b}; A shifts out 0x2000, B 0x1FFF, busy wiggles during readout
    localparam pin_row_t DIRECTED [29] = '{
        {3'b100, 1'b1, START_PULSE},
        {3'b000, 1'b1, BUSY_EDGE},
        {3'b010, 1'b0, NO_CHECK},
        {3'b101, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b110, 1'b0, NO_CHECK},
        {3'b101, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b0, NO_CHECK},
        {3'b010, 1'b0, NO_CHECK},
        {3'b001, 1'b1, FULL_SCALE},
        {3'b111, 1'b0, NO_CHECK}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // sequencer model state
    phase_t                     seq_phase     = PH_START;
    logic [TICK_COUNT_BITS-1:0] wait_ticks    = '0;
    logic [BIT_IDX_W-1:0]       bit_pos       = BIT_IDX_TOP;
    logic [SAMPLE_BITS-1:0]     shift_a       = '0;
    logic [SAMPLE_BITS-1:0]     shift_b       = '0;
    logic                       busy_last     = 1'b1;
    logic [TIMEOUTS_W-1:0]      timeout_tally = '0;
    logic [SAMPLE_BITS-1:0]     hold_raw_a    = '0;
    logic [SAMPLE_BITS-1:0]     hold_raw_b    = '0;
    logic [SCALED_W-1:0]        hold_scaled   = '0;
    logic                       hold_negative = 1'b0;
    logic [GAIN_W-1:0]          gain_reg      = GAIN_RESET;
    logic [TICKS_W-1:0]         timeout_reg   = TIMEOUT_RESET;
    logic [TICKS_W-1:0]         interval_reg  = INTERVAL_RESET;

    // ADC pin generator state
    int                     busy_left = 0;
    logic [SAMPLE_BITS-1:0] code_a    = '0;
    logic [SAMPLE_BITS-1:0] code_b    = '0;

    out_item_t expected_pins [$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    bit        in_burst     = 1'b0;
    bit        out_burst    = 1'b0;

    dual_serial_adc_capture DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic out_item_t predict_pin_tick(in_item_t pins);
        out_item_t                    r;
        logic [SAMPLE_BITS:0]         mag;
        logic [SAMPLE_BITS+GAIN_W:0]  prod;
        logic [SAMPLE_BITS+GAIN_W:0]  scaled;
        r = '0;
        r.start_n      = 1'b1;
        r.serial_clock = 1'b1;
        r.select_n     = 1'b1;
        case (seq_phase)
            PH_START:
            begin
                r.start_n  = 1'b0;
                wait_ticks = '0;
                seq_phase  = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (busy_last && !pins.busy_level)
                begin
                    r.select_n = 1'b0;
                    bit_pos    = BIT_IDX_TOP;
                    shift_a    = '0;
                    shift_b    = '0;
                    seq_phase  = PH_MSB;
                end
                else
                begin
                    if (wait_ticks != '1)
                        wait_ticks++;
                    if (wait_ticks >= timeout_reg)
                    begin
                        r.timed_out = 1'b1;
                        if (timeout_tally != TIMEOUTS_MAX)
                            timeout_tally++;
                        seq_phase = PH_START;
                    end
                end
            end
            PH_MSB:
            begin
                r.select_n       = 1'b0;
                r.serial_clock   = 1'b0;
                shift_a[bit_pos] = shift_a[bit_pos] | pins.data_a_bit;
                shift_b[bit_pos] = shift_b[bit_pos] | pins.data_b_bit;
                bit_pos          = (bit_pos != 0) ? bit_pos - 1'b1 : '0;
                seq_phase        = PH_LOW;
            end
            PH_LOW:
            begin
                shift_a[bit_pos] = shift_a[bit_pos] | pins.data_a_bit;
                shift_b[bit_pos] = shift_b[bit_pos] | pins.data_b_bit;
                if (bit_pos == 0)
                begin
                    hold_negative = shift_a[SAMPLE_BITS-1];
                    if (hold_negative)
                        mag = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, shift_a};
                    else
                        mag = {1'b0, shift_a};
                    prod          = mag * gain_reg;
                    scaled        = prod >> GAIN_FRAC;
                    hold_scaled   = (scaled > SCALED_MAX) ? SCALED_MAX : scaled[SCALED_W-1:0];
                    hold_raw_a    = shift_a;
                    hold_raw_b    = shift_b;
                    timeout_tally = '0;
                    r.sample_valid = 1'b1;
                    wait_ticks    = '0;
                    seq_phase     = PH_IDLE;
                end
                else
                begin
                    r.select_n = 1'b0;
                    bit_pos--;
                    seq_phase = PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                r.select_n     = 1'b0;
                r.serial_clock = 1'b0;
                seq_phase      = PH_LOW;
            end
            default:
            begin
                if (wait_ticks >= interval_reg)
                    seq_phase = PH_START;
                else if (wait_ticks != '1)
                    wait_ticks++;
            end
        endcase
        busy_last = pins.busy_level;
        r.raw_a            = hold_raw_a;
        r.raw_b            = hold_raw_b;
        r.scaled_magnitude = hold_scaled;
        r.negative         = hold_negative;
        r.timeout_count    = timeout_tally;
        return r;
    endfunction

    // behaves like the converter: busy rises at the start pulse and falls after a
    // random conversion time, codes shift out on the bits the sequencer samples
    function automatic in_item_t next_tick(bit stuck);
        in_item_t t;
        int       span;
        if (seq_phase == PH_START)
        begin
            span      = (timeout_reg > 50) ? 51 : int'(timeout_reg) + 1;
            busy_left = 1 + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 80)
                                                          : $urandom_range(0, span));
            code_a = ($urandom_range(0, 3) == 0) ? CORNER_CODES[$urandom_range(0, 3)]
                                                 : SAMPLE_BITS'($urandom);
            code_b = ($urandom_range(0, 3) == 0) ? CORNER_CODES[$urandom_range(0, 3)]
                                                 : SAMPLE_BITS'($urandom);
        end
        t.busy_level = stuck || (busy_left != 0);
        if (busy_left != 0)
            busy_left--;
        if (!stuck && $urandom_range(0, 15) == 0)
            t.busy_level = !t.busy_level;
        if (seq_phase == PH_MSB || seq_phase == PH_LOW)
        begin
            t.data_a_bit = code_a[bit_pos];
            t.data_b_bit = code_b[bit_pos];
        end
        else
        begin
            t.data_a_bit = 1'($urandom_range(0, 1));
            t.data_b_bit = 1'($urandom_range(0, 1));
        end
        return t;
    endfunction

    task automatic send_tick(in_item_t pins, bit typed, out_item_t typed_want);
        int        gap;
        out_item_t predicted;
        if ($urandom_range(0, 49) == 0)
            in_burst = ($urandom_range(0, 2) == 0);
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pins;
        do @(posedge clk); while (!in_ready);
        predicted = predict_pin_tick(pins);
        expected_pins.push_back(typed ? typed_want : predicted);
    endtask

    task automatic run_ticks(int count, bit stuck);
        in_item_t pins;
        repeat (count)
        begin
            pins = next_tick(stuck);
            send_tick(pins, 1'b0, NO_CHECK);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
    endtask

    // spare index first: must be ignored
    task automatic program_regs(logic [CFG_DATA_W-1:0] gain_val,
                                logic [CFG_DATA_W-1:0] timeout_val,
                                logic [CFG_DATA_W-1:0] interval_val);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{CFG_SPARE, CFG_GAIN, CFG_TIMEOUT, CFG_INTERVAL};
        val = '{CFG_DATA_W'($urandom), gain_val, timeout_val, interval_val};
        foreach (idx[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                CFG_GAIN:     gain_reg     = val[k][GAIN_W-1:0];
                CFG_TIMEOUT:  timeout_reg  = val[k];
                CFG_INTERVAL: interval_reg = val[k];
                default:      ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        out_item_t want;
        int        stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                out_burst = ($urandom_range(0, 2) == 0);
            stall = out_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_pins.size() == 0)
            begin
                $error("result with no pending request");
                mismatches++;
            end
            else
            begin
                want = expected_pins.pop_front();
                check_field("start_n", 32'(want.start_n), 32'(out_data.start_n));
                check_field("serial_clock", 32'(want.serial_clock),
                            32'(out_data.serial_clock));
                check_field("select_n", 32'(want.select_n), 32'(out_data.select_n));
                check_field("sample_valid", 32'(want.sample_valid),
                            32'(out_data.sample_valid));
                check_field("timed_out", 32'(want.timed_out), 32'(out_data.timed_out));
                check_field("raw_a", 32'(want.raw_a), 32'(out_data.raw_a));
                check_field("raw_b", 32'(want.raw_b), 32'(out_data.raw_b));
                check_field("scaled_magnitude", 32'(want.scaled_magnitude),
                            32'(out_data.scaled_magnitude));
                check_field("negative", 32'(want.negative), 32'(out_data.negative));
                check_field("timeout_count", 32'(want.timeout_count),
                            32'(out_data.timeout_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
            send_tick(DIRECTED[r].pins, DIRECTED[r].typed, DIRECTED[r].want);
        settle();

        // zero gain, one-tick timeout; busy stuck high saturates the timeout count
        program_regs('0, 24'd1, '0);
        run_ticks(520, 1'b1);
        run_ticks(100, 1'b0);
        settle();

        // full gain with masked upper bits, longest timeout
        program_regs('1, '1, 24'd3);
        run_ticks(120, 1'b0);
        settle();

        // zero timeout
        program_regs(CFG_DATA_W'($urandom), '0, '0);
        run_ticks(100, 1'b0);
        settle();

        repeat (4)
        begin
            program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(2, 40)),
                         CFG_DATA_W'($urandom_range(0, 30)));
            run_ticks(100, 1'b0);
            settle();
        end

        // longest interval: sequencer parks after the first good read
        program_regs(CFG_DATA_W'(GAIN_RESET), 24'd6, '1);
        run_ticks(60, 1'b0);
        settle();

        program_regs(CFG_DATA_W'($urandom), 24'd12, 24'd2);
        run_ticks(60, 1'b0);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
